// ===== rtl/vdi_pkg.sv =====
// Package with the constants and types shared by the vertex deduplication indexer.
`timescale 1ns / 1ps
package vdi_pkg;

    // Table capacity in unique vertices.
    localparam int MAX_UNIQUE = 1024;

    // Number of cells in the search chain; entry i lives in cell i % NCELL.
    localparam int NCELL      = (MAX_UNIQUE >= 16) ? 16 : 2;
    localparam int CW         = $clog2(NCELL);
    localparam int ROWS_NEED  = (MAX_UNIQUE + NCELL - 1) / NCELL;
    localparam int AW         = (ROWS_NEED > 1) ? $clog2(ROWS_NEED) : 1;
    localparam int BANK_DEPTH = 1 << AW;
    localparam int ROW_W      = AW + 1;

    // Index and count widths.
    localparam int IDX_W = $clog2(MAX_UNIQUE);
    localparam int CNT_W = $clog2(MAX_UNIQUE + 1);
    localparam int CMP_W = AW + CW + 1;

    // Fixed widths of the result fields.
    localparam int OUT_IDX_W = 10;
    localparam int OUT_CNT_W = 11;

    // One full vertex tuple as it is stored and compared.
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
        logic [31:0] bone_ids;
        logic [63:0] weights_low;
        logic [63:0] weights_high;
    } t_vtx;

    // Search token that walks the chain, one per table row.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [AW-1:0]    addr;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_tok;

    // Write request into one cell bank.
    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        t_vtx          data;
    } t_wr;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

// ===== rtl/vdi_cell.sv =====
// One search cell: a bank of the vertex table and a two-stage compare on the passing token.
`timescale 1ns / 1ps
module vdi_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [vdi_pkg::CW-1:0]   i_cell_id,
    input  vdi_pkg::t_tok            i_tok,
    input  vdi_pkg::t_vtx            i_key,
    input  logic [vdi_pkg::CNT_W-1:0] i_count,
    input  vdi_pkg::t_wr             i_wr,
    output vdi_pkg::t_tok            o_tok
);

    vdi_pkg::t_vtx r_mem [vdi_pkg::BANK_DEPTH];
    vdi_pkg::t_vtx r_rdata;
    vdi_pkg::t_tok r_tok1;
    vdi_pkg::t_tok r_tok2;
    vdi_pkg::t_tok n_tok2;

    logic [vdi_pkg::AW+vdi_pkg::CW-1:0] w_entry;
    logic                               w_match;

    // Bank write port and registered read at the token's row.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_tok.addr];
    end

    // First stage holds the token while the bank read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1 <= '0;
        end else begin
            r_tok1 <= i_tok;
        end
    end

    // Compare the stored entry against the key; only entries below the count take part.
    assign w_entry = {r_tok1.addr, i_cell_id};
    assign w_match = r_tok1.valid && !r_tok1.found
                     && (vdi_pkg::CMP_W'(w_entry) < vdi_pkg::CMP_W'(i_count))
                     && (r_rdata == i_key);

    always_comb begin
        n_tok2 = r_tok1;
        if (w_match) begin
            n_tok2.found = 1'b1;
            n_tok2.idx   = vdi_pkg::IDX_W'(w_entry);
        end
    end

    // Second stage hands the token to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok2 <= '0;
        end else begin
            r_tok2 <= n_tok2;
        end
    end

    assign o_tok = r_tok2;

    // A token that arrives already matched keeps its earlier index.
    a_keep_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok1.valid && r_tok1.found |=> r_tok2.found && r_tok2.idx == $past(r_tok1.idx))
        else $error("cell overwrote an earlier match");

    // Tokens leave in the same order and spacing as they arrive.
    a_token_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok.valid |-> ##2 (r_tok2.valid && r_tok2.addr == $past(i_tok.addr, 2)))
        else $error("cell lost or reordered a token");

    // A match is only reported on a live entry.
    a_live_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_match |-> (vdi_pkg::CMP_W'(w_entry) < vdi_pkg::CMP_W'(i_count)))
        else $error("match on an entry beyond the count");

endmodule

// ===== rtl/vertex_dedup_indexer_core.sv =====
// Top level of the vertex deduplication indexer: sequencer, cell chain and result register.
// A lookup sweeps ceil(count / 16) table rows through the cell chain and then finishes (an empty
// table goes straight to the finish step), count being the stored vertices after any mesh restart.
// Throughput: one word at a time, the next taken once the last result is registered; a held result stalls intake.
// Reset clears the vertex count, the sequencer and all valid flags; the table banks are not
// cleared, entries beyond the count are never compared.
`timescale 1ns / 1ps
module vertex_dedup_indexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_first_of_mesh,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_tex_u,
    input  logic [31:0] i_tex_v,
    input  logic [31:0] i_norm_x,
    input  logic [31:0] i_norm_y,
    input  logic [31:0] i_norm_z,
    input  logic [31:0] i_bone_ids,
    input  logic [63:0] i_weights_low,
    input  logic [63:0] i_weights_high,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [9:0]  o_vertex_index,
    output logic        o_is_new,
    output logic        o_overflow,
    output logic [10:0] o_unique_count
);

    vdi_pkg::t_state r_state;
    vdi_pkg::t_state n_state;

    vdi_pkg::t_vtx r_key;
    logic [vdi_pkg::CNT_W-1:0] r_count;
    logic [vdi_pkg::CNT_W-1:0] w_count_eff;
    logic [vdi_pkg::ROW_W-1:0] r_rows;
    logic [vdi_pkg::ROW_W-1:0] w_rows;
    logic [vdi_pkg::CMP_W-1:0] w_row_sum;
    logic [vdi_pkg::ROW_W-1:0] r_issue;
    logic                      r_found;
    logic [vdi_pkg::IDX_W-1:0] r_fidx;

    logic [vdi_pkg::IDX_W-1:0] r_res_idx;
    logic                      r_res_new;
    logic                      r_res_ovf;
    logic [vdi_pkg::CNT_W-1:0] r_res_cnt;
    logic                      r_out_valid;

    logic w_accept;
    logic w_issue;
    logic w_finish;
    logic w_out_free;
    logic w_last_issue;
    logic w_store;
    logic [vdi_pkg::CMP_W-1:0] w_wpos;

    vdi_pkg::t_tok w_tok [vdi_pkg::NCELL+1];
    vdi_pkg::t_wr  w_wr  [vdi_pkg::NCELL];
    vdi_pkg::t_tok w_exit;

    // Input side handshake and effective count after a mesh restart.
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_count_eff = i_first_of_mesh ? '0 : r_count;

    // Rows to sweep: ceil(count / NCELL).
    assign w_row_sum = vdi_pkg::CMP_W'(w_count_eff) + vdi_pkg::CMP_W'(vdi_pkg::NCELL - 1);
    assign w_rows    = vdi_pkg::ROW_W'(w_row_sum >> vdi_pkg::CW);

    assign w_last_issue = (r_issue == r_rows - vdi_pkg::ROW_W'(1));
    assign w_exit       = w_tok[vdi_pkg::NCELL];
    assign w_out_free   = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vdi_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_rows == '0) ? vdi_pkg::S_FINISH : vdi_pkg::S_SWEEP;
                end
            end
            vdi_pkg::S_SWEEP: begin
                if (w_last_issue) begin
                    n_state = vdi_pkg::S_DRAIN;
                end
            end
            vdi_pkg::S_DRAIN: begin
                if (w_exit.valid && w_exit.last) begin
                    n_state = vdi_pkg::S_FINISH;
                end
            end
            vdi_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = vdi_pkg::S_IDLE;
                end
            end
            default: n_state = vdi_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready = (r_state == vdi_pkg::S_IDLE);
        w_issue    = (r_state == vdi_pkg::S_SWEEP);
        w_finish   = (r_state == vdi_pkg::S_FINISH) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the key on accept.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key.pos_x        <= i_pos_x;
            r_key.pos_y        <= i_pos_y;
            r_key.pos_z        <= i_pos_z;
            r_key.tex_u        <= i_tex_u;
            r_key.tex_v        <= i_tex_v;
            r_key.norm_x       <= i_norm_x;
            r_key.norm_y       <= i_norm_y;
            r_key.norm_z       <= i_norm_z;
            r_key.bone_ids     <= i_bone_ids;
            r_key.weights_low  <= i_weights_low;
            r_key.weights_high <= i_weights_high;
            r_rows             <= w_rows;
        end
    end

    // Row issue counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
        end else if (w_accept) begin
            r_issue <= '0;
        end else if (w_issue) begin
            r_issue <= r_issue + vdi_pkg::ROW_W'(1);
        end
    end

    // Token entering the first cell.
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_issue;
        w_tok[0].last  = w_last_issue;
        w_tok[0].addr  = r_issue[vdi_pkg::AW-1:0];
    end

    // Rows leave the chain in ascending order; the first matched row holds the lowest index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (w_accept) begin
            r_found <= 1'b0;
        end else if (w_exit.valid && w_exit.found && !r_found) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit.valid && w_exit.found && !r_found) begin
            r_fidx <= w_exit.idx;
        end
    end

    // Append position for a new vertex.
    assign w_store = w_finish && !r_found
                     && (vdi_pkg::CMP_W'(r_count) < vdi_pkg::CMP_W'(vdi_pkg::MAX_UNIQUE));
    assign w_wpos  = vdi_pkg::CMP_W'(r_count);

    // Cell chain.
    for (genvar k = 0; k < vdi_pkg::NCELL; k++) begin : g_cell
        assign w_wr[k].en   = w_store && (w_wpos[vdi_pkg::CW-1:0] == vdi_pkg::CW'(k));
        assign w_wr[k].addr = w_wpos[vdi_pkg::AW+vdi_pkg::CW-1:vdi_pkg::CW];
        assign w_wr[k].data = r_key;

        vdi_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (vdi_pkg::CW'(k)),
            .i_tok     (w_tok[k]),
            .i_key     (r_key),
            .i_count   (r_count),
            .i_wr      (w_wr[k]),
            .o_tok     (w_tok[k+1])
        );
    end

    // Vertex count: cleared on a mesh restart, bumped on append.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= w_count_eff;
        end else if (w_store) begin
            r_count <= r_count + vdi_pkg::CNT_W'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            if (r_found) begin
                r_res_idx <= r_fidx;
                r_res_new <= 1'b0;
                r_res_ovf <= 1'b0;
                r_res_cnt <= r_count;
            end else if (w_store) begin
                r_res_idx <= vdi_pkg::IDX_W'(r_count);
                r_res_new <= 1'b1;
                r_res_ovf <= 1'b0;
                r_res_cnt <= r_count + vdi_pkg::CNT_W'(1);
            end else begin
                r_res_idx <= '0;
                r_res_new <= 1'b0;
                r_res_ovf <= 1'b1;
                r_res_cnt <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = vdi_pkg::OUT_IDX_W'(r_res_idx);
    assign o_is_new       = r_res_new;
    assign o_overflow     = r_res_ovf;
    assign o_unique_count = vdi_pkg::OUT_CNT_W'(r_res_cnt);

    // The count never passes the table capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vdi_pkg::CMP_W'(r_count) <= vdi_pkg::CMP_W'(vdi_pkg::MAX_UNIQUE))
        else $error("vertex count beyond capacity");

    // Tokens only leave the chain while a search is running.
    a_exit_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> (r_state == vdi_pkg::S_SWEEP || r_state == vdi_pkg::S_DRAIN))
        else $error("stray token at the end of the chain");

    // An appended vertex is always the last one in the table.
    a_new_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_new |-> (vdi_pkg::CNT_W'(r_res_idx) + vdi_pkg::CNT_W'(1) == r_res_cnt))
        else $error("new vertex index does not match the count");

    // Overflow only with a full table and never together with a new vertex.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res_ovf |->
            (!r_res_new && vdi_pkg::CMP_W'(r_res_cnt) == vdi_pkg::CMP_W'(vdi_pkg::MAX_UNIQUE)))
        else $error("overflow reported below capacity");

    // A taken word starts either a sweep or, for an empty table, the finish step.
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == vdi_pkg::S_SWEEP || r_state == vdi_pkg::S_FINISH))
        else $error("sequencer did not start after accept");

endmodule

// ===== tb/vertex_dedup_indexer_checker.sv =====
// Checker that predicts and compares every lookup of the vertex deduplication indexer.
`timescale 1ns / 1ps
module vertex_dedup_indexer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_first_of_mesh,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_tex_u,
    input  logic [31:0] i_tex_v,
    input  logic [31:0] i_norm_x,
    input  logic [31:0] i_norm_y,
    input  logic [31:0] i_norm_z,
    input  logic [31:0] i_bone_ids,
    input  logic [63:0] i_weights_low,
    input  logic [63:0] i_weights_high,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [9:0]  i_vertex_index,
    input  logic        i_is_new,
    input  logic        i_overflow,
    input  logic [10:0] i_unique_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_new_seen,
    output int          o_overflow_seen
);

    // Expected contents of one result word.
    typedef struct packed {
        logic [vdi_pkg::OUT_IDX_W-1:0] vertex_index;
        logic                          is_new;
        logic                          overflow;
        logic [vdi_pkg::OUT_CNT_W-1:0] unique_count;
    } t_lookup;

    // Shadow copy of the unique vertex table of the current mesh.
    vdi_pkg::t_vtx vtx_table [vdi_pkg::MAX_UNIQUE];
    int unsigned   table_fill;

    t_lookup     expected_lookups [$];
    int          fail_total     = 0;
    int          pending_total  = 0;
    int          checked_total  = 0;
    int          new_total      = 0;
    int          overflow_total = 0;

    assign o_fail_count    = fail_total;
    assign o_pending       = pending_total;
    assign o_checked       = checked_total;
    assign o_new_seen      = new_total;
    assign o_overflow_seen = overflow_total;

    // Looks a corner up in the shadow table, appending it when it is not there yet.
    function automatic t_lookup resolve_corner(input vdi_pkg::t_vtx corner, input logic first);
        t_lookup     res;
        bit          hit;
        int unsigned k;
        res = '0;
        hit = 1'b0;
        if (first) begin
            table_fill = 0;
        end
        // Earliest bit-exact match wins.
        for (k = 0; k < table_fill && !hit; k++) begin
            if (vtx_table[k] == corner) begin
                res.vertex_index = k[vdi_pkg::OUT_IDX_W-1:0];
                hit = 1'b1;
            end
        end
        if (!hit) begin
            if (table_fill < vdi_pkg::MAX_UNIQUE) begin
                vtx_table[table_fill] = corner;
                res.vertex_index = table_fill[vdi_pkg::OUT_IDX_W-1:0];
                res.is_new = 1'b1;
                table_fill++;
            end else begin
                // Full table: nothing stored, index reads as zero.
                res.overflow = 1'b1;
            end
        end
        res.unique_count = table_fill[vdi_pkg::OUT_CNT_W-1:0];
        return res;
    endfunction

    // Compare the result word first, then predict the corner word taken at the same edge.
    always @(posedge i_clk) begin
        vdi_pkg::t_vtx corner;
        t_lookup       want;
        int            errors;
        if (!i_rst_n) begin
            table_fill = 0;
            expected_lookups.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_lookups.size() == 0) begin
                    $error("result word with no corner outstanding: vertex_index %0d",
                           i_vertex_index);
                    fail_total++;
                end else begin
                    want = expected_lookups.pop_front();
                    errors = 0;
                    if (i_vertex_index !== want.vertex_index) begin
                        $error("vertex_index mismatch: expected %0d, actual %0d",
                               want.vertex_index, i_vertex_index);
                        errors++;
                    end
                    if (i_is_new !== want.is_new) begin
                        $error("is_new mismatch: expected %0d, actual %0d",
                               want.is_new, i_is_new);
                        errors++;
                    end
                    if (i_overflow !== want.overflow) begin
                        $error("overflow mismatch: expected %0d, actual %0d",
                               want.overflow, i_overflow);
                        errors++;
                    end
                    if (i_unique_count !== want.unique_count) begin
                        $error("unique_count mismatch: expected %0d, actual %0d",
                               want.unique_count, i_unique_count);
                        errors++;
                    end
                    fail_total += errors;
                    checked_total++;
                    new_total += want.is_new;
                    overflow_total += want.overflow;
                end
            end
            if (i_in_valid && i_in_ready) begin
                corner.pos_x        = i_pos_x;
                corner.pos_y        = i_pos_y;
                corner.pos_z        = i_pos_z;
                corner.tex_u        = i_tex_u;
                corner.tex_v        = i_tex_v;
                corner.norm_x       = i_norm_x;
                corner.norm_y       = i_norm_y;
                corner.norm_z       = i_norm_z;
                corner.bone_ids     = i_bone_ids;
                corner.weights_low  = i_weights_low;
                corner.weights_high = i_weights_high;
                expected_lookups.insert(expected_lookups.size(),
                                        resolve_corner(corner, i_first_of_mesh));
            end
        end
        pending_total = expected_lookups.size();
    end

endmodule

// ===== tb/vertex_dedup_indexer_core_test.sv =====
// Testbench top for the vertex deduplication indexer: stimulus, backpressure and verdict.
`timescale 1ns / 1ps
module vertex_dedup_indexer_core_test;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_CORNERS = 80;
    localparam int OVERFLOW_EXTRA = 16;
    localparam int VTX_W          = $bits(vdi_pkg::t_vtx);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_first_of_mesh = 1'b0;
    logic [31:0] i_pos_x = '0;
    logic [31:0] i_pos_y = '0;
    logic [31:0] i_pos_z = '0;
    logic [31:0] i_tex_u = '0;
    logic [31:0] i_tex_v = '0;
    logic [31:0] i_norm_x = '0;
    logic [31:0] i_norm_y = '0;
    logic [31:0] i_norm_z = '0;
    logic [31:0] i_bone_ids = '0;
    logic [63:0] i_weights_low = '0;
    logic [63:0] i_weights_high = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [9:0]  o_vertex_index;
    logic        o_is_new;
    logic        o_overflow;
    logic [10:0] o_unique_count;

    int            fail_count;
    int            pending;
    int            checked;
    int            new_seen;
    int            overflow_seen;
    int unsigned   cycle_count = 0;
    int unsigned   corners_sent = 0;
    int unsigned   meshes = 0;
    bit            calm = 1'b0;
    int unsigned   out_stall_left = 0;
    vdi_pkg::t_vtx fill_set [vdi_pkg::MAX_UNIQUE];

    vertex_dedup_indexer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_of_mesh(i_first_of_mesh),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_tex_u        (i_tex_u),
        .i_tex_v        (i_tex_v),
        .i_norm_x       (i_norm_x),
        .i_norm_y       (i_norm_y),
        .i_norm_z       (i_norm_z),
        .i_bone_ids     (i_bone_ids),
        .i_weights_low  (i_weights_low),
        .i_weights_high (i_weights_high),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_vertex_index (o_vertex_index),
        .o_is_new       (o_is_new),
        .o_overflow     (o_overflow),
        .o_unique_count (o_unique_count)
    );

    vertex_dedup_indexer_checker u_lookup_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_first_of_mesh(i_first_of_mesh),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_tex_u        (i_tex_u),
        .i_tex_v        (i_tex_v),
        .i_norm_x       (i_norm_x),
        .i_norm_y       (i_norm_y),
        .i_norm_z       (i_norm_z),
        .i_bone_ids     (i_bone_ids),
        .i_weights_low  (i_weights_low),
        .i_weights_high (i_weights_high),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_vertex_index (o_vertex_index),
        .i_is_new       (o_is_new),
        .i_overflow     (o_overflow),
        .i_unique_count (o_unique_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_new_seen     (new_seen),
        .o_overflow_seen(overflow_seen)
    );

    // Free-running clock.
    always #2 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result backpressure: mostly short stalls, a few long ones, no new ones while calm.
    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            i_out_ready <= 1'b0;
            out_stall_left <= out_stall_left - 1;
        end else if (!calm && $urandom_range(99) < 30) begin
            i_out_ready <= 1'b0;
            out_stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                       : $urandom_range(2, 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Fully random corner tuple.
    function automatic vdi_pkg::t_vtx random_corner();
        vdi_pkg::t_vtx v;
        v.pos_x        = $urandom;
        v.pos_y        = $urandom;
        v.pos_z        = $urandom;
        v.tex_u        = $urandom;
        v.tex_v        = $urandom;
        v.norm_x       = $urandom;
        v.norm_y       = $urandom;
        v.norm_z       = $urandom;
        v.bone_ids     = $urandom;
        v.weights_low  = {$urandom, $urandom};
        v.weights_high = {$urandom, $urandom};
        return v;
    endfunction

    // Flips one random bit inside field number fld (0 is pos_x, 10 is weights_high).
    function automatic vdi_pkg::t_vtx flip_field_bit(input vdi_pkg::t_vtx v, input int fld);
        logic [VTX_W-1:0] mask;
        int               lo;
        int               w;
        if (fld < 9) begin
            lo = 384 - 32 * fld;
            w  = 32;
        end else begin
            lo = (fld == 9) ? 64 : 0;
            w  = 64;
        end
        mask = '0;
        mask[lo + $urandom_range(w - 1)] = 1'b1;
        return vdi_pkg::t_vtx'(v ^ mask);
    endfunction

    // Idle cycles before the next corner word.
    function automatic int pick_idle_gap();
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // Presents one corner word and holds it until it is taken.
    task automatic send_corner(input vdi_pkg::t_vtx v, input logic first);
        int gap;
        gap = pick_idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_first_of_mesh <= first;
        i_pos_x         <= v.pos_x;
        i_pos_y         <= v.pos_y;
        i_pos_z         <= v.pos_z;
        i_tex_u         <= v.tex_u;
        i_tex_v         <= v.tex_v;
        i_norm_x        <= v.norm_x;
        i_norm_y        <= v.norm_y;
        i_norm_z        <= v.norm_z;
        i_bone_ids      <= v.bone_ids;
        i_weights_low   <= v.weights_low;
        i_weights_high  <= v.weights_high;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        corners_sent++;
        if (first) begin
            meshes++;
        end
    endtask

    // Stops sending and waits until every outstanding lookup has returned.
    task automatic settle_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        vdi_pkg::t_vtx zero_v;
        vdi_pkg::t_vtx ones_v;
        vdi_pkg::t_vtx neg_zero_v;
        vdi_pkg::t_vtx nan_v;
        vdi_pkg::t_vtx base_v;
        vdi_pkg::t_vtx v;
        vdi_pkg::t_vtx pool [$];
        int            f;
        int            c;
        int            mesh_size;
        int            pool_size;
        int            budget;
        int unsigned   r;
        int unsigned   stored;
        int unsigned   new_sent;
        bit            big;

        // Reset once, released at a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, signed zero and NaN compared as bits, one-bit differences.
        zero_v = '0;
        ones_v = '1;
        neg_zero_v = '0;
        neg_zero_v.pos_x = 32'h8000_0000;
        nan_v = '0;
        nan_v.pos_x = 32'h7FC0_0000;
        nan_v.norm_y = 32'hFFC0_0001;
        base_v = random_corner();
        send_corner(zero_v, 1'b1);
        send_corner(zero_v, 1'b0);
        send_corner(ones_v, 1'b0);
        send_corner(neg_zero_v, 1'b0);
        send_corner(nan_v, 1'b0);
        send_corner(nan_v, 1'b0);
        send_corner(ones_v, 1'b0);
        send_corner(base_v, 1'b0);
        for (f = 0; f < 11; f++) begin
            send_corner(flip_field_bit(base_v, f), 1'b0);
        end
        // A new mesh forgets the old table, even on back-to-back mesh starts.
        send_corner(ones_v, 1'b1);
        send_corner(ones_v, 1'b1);
        settle_results();

        // Random meshes built from a small pool of tuples, with near-duplicates and noise.
        while (corners_sent < RANDOM_CORNERS + 21) begin
            big = ($urandom_range(7) == 0);
            mesh_size = big ? $urandom_range(300, 100) : $urandom_range(50, 1);
            pool_size = big ? $urandom_range(200, 20) : $urandom_range(24, 1);
            budget = RANDOM_CORNERS + 21 - int'(corners_sent);
            if (mesh_size > budget) begin
                mesh_size = budget;
            end
            calm = ($urandom_range(3) == 0);
            pool.delete();
            for (c = 0; c < pool_size; c++) begin
                pool.insert(pool.size(), random_corner());
            end
            for (c = 0; c < mesh_size; c++) begin
                r = $urandom_range(99);
                if (r < 78) begin
                    v = pool[$urandom_range(pool_size - 1)];
                end else if (r < 92) begin
                    v = flip_field_bit(pool[$urandom_range(pool_size - 1)], $urandom_range(10));
                end else begin
                    v = random_corner();
                end
                send_corner(v, (c == 0) || ($urandom_range(99) < 3));
            end
            if ($urandom_range(3) == 0) begin
                settle_results();
            end
        end
        settle_results();

        // One mesh that fills the table and then runs past its capacity.
        calm = 1'b0;
        stored = 0;
        new_sent = 0;
        while (new_sent < vdi_pkg::MAX_UNIQUE + OVERFLOW_EXTRA) begin
            if (stored > 0 && $urandom_range(99) < 5) begin
                send_corner(fill_set[$urandom_range(stored - 1)], 1'b0);
            end else begin
                v = random_corner();
                if (stored < vdi_pkg::MAX_UNIQUE) begin
                    fill_set[stored] = v;
                    stored++;
                end
                send_corner(v, new_sent == 0);
                new_sent++;
            end
        end
        // Matches at both ends of a full table, then a fresh mesh.
        send_corner(fill_set[vdi_pkg::MAX_UNIQUE - 1], 1'b0);
        send_corner(fill_set[0], 1'b0);
        send_corner(fill_set[vdi_pkg::MAX_UNIQUE - 1], 1'b1);

        // Drain and give the verdict.
        settle_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d corners over %0d meshes, one of them filled past %0d entries.",
                 corners_sent, meshes, vdi_pkg::MAX_UNIQUE);
        $display("%0d result words checked: %0d new vertices, %0d overflows, %0d matches.",
                 checked, new_seen, overflow_seen, checked - new_seen - overflow_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
